// ===== rtl/core/rcr_pkg.sv =====
// Shared types and constants for the railroad car rearranger.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rcr_pkg;

    localparam int MAX_TRACKS  = 8;
    localparam int MAX_CARS    = 32;
    localparam int STACK_DEPTH = 32;
    localparam int MAX_RESULTS = 32;

    localparam int CAR_W  = 6;
    localparam int CNT_W  = 4;
    localparam int STAT_W = 2;
    localparam int TRK_W  = $clog2(MAX_TRACKS);
    localparam int HGT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W = $clog2(STACK_DEPTH);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_W = TRK_W + SLOT_W;

    localparam logic [STAT_W-1:0] STAT_MOVED     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL_NOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FAIL_HELD = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DRAIN,
        ST_TOPLOAD,
        ST_PUSH_SCAN,
        ST_PUSH_DO,
        ST_FINISH
    } rcr_state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CAR_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } rcr_mem_req_t;

    typedef struct packed {
        logic eq;          // top equals operand
        logic fits;        // operand < top <= MAX_CARS
        logic below_best;  // top < best top so far
    } rcr_cmp_t;

endpackage

// ===== rtl/core/railroad_car_rearranger_unit.sv =====
// Per car: a car that parks or finds no track scans each track in use once, a report while
// already failed scans none, and a car that leaves directly visits each track in use on
// each drain scan, with a top refill from the car store per car drained; stalls add to all.
// One car at a time: s_tready is high only between cars; the car's last word goes valid
// in that same cycle. Reset (aresetn low, synchronous): empties all tracks, next car 1,
// failure cleared, track count 8, output empty; no clearing pass is needed.
`timescale 1ns / 1ps

module railroad_car_rearranger_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration: track count
    input  logic                      cfg_wr_en,
    input  logic [rcr_pkg::CNT_W-1:0] cfg_wr_data,
    // input cars
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [5:0] car
    input  logic                      s_tuser,   // [0] new_train
    // moves
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,   // [5:0] moved_car, [9:6] from, [13:10] to
    output logic [1:0]                m_tuser,   // [1:0] status
    output logic                      m_tlast
);
    import rcr_pkg::*;

    // sequencer state
    rcr_state_t        state_reg, state_next;
    logic [CAR_W-1:0]  car_reg, car_next;
    logic [CAR_W-1:0]  next_exp_reg, next_exp_next;
    logic              failed_reg, failed_next;
    logic [CNT_W-1:0]  tc_reg, tc_next;
    logic [TRK_W-1:0]  j_reg, j_next;
    logic [RES_W-1:0]  n_reg, n_next;
    logic              moved_reg, moved_next;

    // push search
    logic              hb_reg, hb_next;
    logic [TRK_W-1:0]  best_reg, best_next;
    logic [CAR_W-1:0]  best_top_reg, best_top_next;
    logic [HGT_W-1:0]  best_h_reg, best_h_next;
    logic              he_reg, he_next;
    logic [TRK_W-1:0]  empty_reg, empty_next;

    // track heights and cached tops
    logic [HGT_W-1:0]  height_reg [MAX_TRACKS];
    logic [HGT_W-1:0]  height_next [MAX_TRACKS];
    logic [CAR_W-1:0]  top_reg [MAX_TRACKS];
    logic [CAR_W-1:0]  top_next [MAX_TRACKS];

    // pending move (held until the following one shows whether it is the last)
    logic              pend_valid_reg, pend_valid_next;
    logic [CAR_W-1:0]  pend_car_reg, pend_car_next;
    logic [CNT_W-1:0]  pend_from_reg, pend_from_next;
    logic [CNT_W-1:0]  pend_to_reg, pend_to_next;
    logic [STAT_W-1:0] pend_stat_reg, pend_stat_next;

    // output word
    logic              m_valid_reg, m_valid_next;
    logic [CAR_W-1:0]  m_car_reg, m_car_next;
    logic [CNT_W-1:0]  m_from_reg, m_from_next;
    logic [CNT_W-1:0]  m_to_reg, m_to_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;
    logic              m_last_reg, m_last_next;

    // combinational helpers
    rcr_mem_req_t      mem_req;
    logic [CAR_W-1:0]  mem_rd_data;
    rcr_cmp_t          cmp;
    logic [CAR_W-1:0]  cmp_operand;
    logic [CNT_W-1:0]  k_eff;
    logic              j_last;
    logic [HGT_W-1:0]  h_j;
    logic [CAR_W-1:0]  top_j;
    logic              drain_hit;
    logic              slot_free;
    logic              can_emit;
    logic              emit_en;
    logic [CAR_W-1:0]  emit_car;
    logic [CNT_W-1:0]  emit_from;
    logic [CNT_W-1:0]  emit_to;
    logic [STAT_W-1:0] emit_stat;
    logic              fin_en;
    rcr_state_t        adv_state;
    logic [TRK_W-1:0]  adv_j;
    logic              adv_moved;
    logic [TRK_W-1:0]  pick;
    logic [HGT_W-1:0]  pick_h;

    rcr_track_mem u_mem (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    rcr_cmp_unit u_cmp (
        .operand  (cmp_operand),
        .top      (top_j),
        .best_top (best_top_reg),
        .res      (cmp)
    );

    // A track count above the hardware count is treated as the hardware count.
    assign k_eff       = (tc_reg > CNT_W'(MAX_TRACKS)) ? CNT_W'(MAX_TRACKS) : tc_reg;
    assign j_last      = (CNT_W'(j_reg) == k_eff - CNT_W'(1));
    assign h_j         = height_reg[j_reg];
    assign top_j       = top_reg[j_reg];
    assign cmp_operand = (state_reg == ST_DRAIN) ? next_exp_reg : car_reg;
    assign drain_hit   = (h_j != '0) && (h_j <= HGT_W'(STACK_DEPTH)) && cmp.eq;
    assign slot_free   = !m_valid_reg || m_tready;
    assign can_emit    = !pend_valid_reg || slot_free;
    assign pick        = hb_reg ? best_reg : empty_reg;
    assign pick_h      = hb_reg ? best_h_reg : '0;

    // Step the drain scan on to the next track, restart it, or stop.
    always_comb begin
        adv_state = ST_DRAIN;
        adv_j     = j_reg + TRK_W'(1);
        adv_moved = moved_reg;
        if (n_reg == RES_W'(MAX_RESULTS)) begin
            adv_state = ST_FINISH;
        end else if (j_last) begin
            adv_j     = '0;
            adv_moved = 1'b0;
            if (!moved_reg) begin
                adv_state = ST_FINISH;
            end
        end
    end

    // Sequencer: next state and datapath control.
    always_comb begin
        state_next    = state_reg;
        car_next      = car_reg;
        next_exp_next = next_exp_reg;
        failed_next   = failed_reg;
        tc_next       = cfg_wr_en ? cfg_wr_data : tc_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        moved_next    = moved_reg;
        hb_next       = hb_reg;
        best_next     = best_reg;
        best_top_next = best_top_reg;
        best_h_next   = best_h_reg;
        he_next       = he_reg;
        empty_next    = empty_reg;
        height_next   = height_reg;
        top_next      = top_reg;
        mem_req       = '0;
        emit_en       = 1'b0;
        emit_car      = '0;
        emit_from     = '0;
        emit_to       = '0;
        emit_stat     = STAT_MOVED;
        fin_en        = 1'b0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    car_next = s_tdata[CAR_W-1:0];
                    // new train: empty every track, clear the failure and start again from car 1
                    if (s_tuser) begin
                        for (int t = 0; t < MAX_TRACKS; t++) begin
                            height_next[t] = '0;
                        end
                        failed_next   = 1'b0;
                        next_exp_next = CAR_W'(1);
                    end
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH: begin
                if (can_emit) begin
                    if (failed_reg) begin
                        emit_en    = 1'b1;
                        emit_stat  = STAT_FAIL_HELD;
                        state_next = ST_FINISH;
                    end else if (car_reg == next_exp_reg) begin
                        // straight through to the output, then drain the tracks
                        emit_en       = 1'b1;
                        emit_car      = car_reg;
                        next_exp_next = next_exp_reg + CAR_W'(1);
                        n_next        = RES_W'(1);
                        j_next        = '0;
                        moved_next    = 1'b0;
                        state_next    = (k_eff == '0) ? ST_FINISH : ST_DRAIN;
                    end else begin
                        j_next     = '0;
                        hb_next    = 1'b0;
                        he_next    = 1'b0;
                        state_next = (k_eff == '0) ? ST_PUSH_DO : ST_PUSH_SCAN;
                    end
                end
            end

            ST_DRAIN: begin
                if (drain_hit) begin
                    if (can_emit) begin
                        emit_en            = 1'b1;
                        emit_car           = top_j;
                        emit_from          = CNT_W'(j_reg) + CNT_W'(1);
                        height_next[j_reg] = h_j - HGT_W'(1);
                        next_exp_next      = next_exp_reg + CAR_W'(1);
                        n_next             = n_reg + RES_W'(1);
                        moved_next         = 1'b1;
                        // fetch the car now exposed on this track
                        if (h_j >= HGT_W'(2)) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = {j_reg, SLOT_W'(h_j - HGT_W'(2))};
                        end
                        state_next = ST_TOPLOAD;
                    end
                end else begin
                    j_next     = adv_j;
                    moved_next = adv_moved;
                    state_next = adv_state;
                end
            end

            ST_TOPLOAD: begin
                if (h_j != '0) begin
                    top_next[j_reg] = mem_rd_data;
                end
                j_next     = adv_j;
                moved_next = adv_moved;
                state_next = adv_state;
            end

            ST_PUSH_SCAN: begin
                if (h_j != '0) begin
                    // full tracks are never chosen
                    if (h_j < HGT_W'(STACK_DEPTH) && cmp.fits &&
                        (!hb_reg || cmp.below_best)) begin
                        hb_next       = 1'b1;
                        best_next     = j_reg;
                        best_top_next = top_j;
                        best_h_next   = h_j;
                    end
                end else if (!he_reg) begin
                    he_next    = 1'b1;
                    empty_next = j_reg;
                end
                if (j_last) begin
                    state_next = ST_PUSH_DO;
                end else begin
                    j_next = j_reg + TRK_W'(1);
                end
            end

            ST_PUSH_DO: begin
                if (can_emit) begin
                    emit_en = 1'b1;
                    if (hb_reg || he_reg) begin
                        mem_req.wr_en     = 1'b1;
                        mem_req.wr_addr   = {pick, pick_h[SLOT_W-1:0]};
                        mem_req.wr_data   = car_reg;
                        height_next[pick] = pick_h + HGT_W'(1);
                        top_next[pick]    = car_reg;
                        emit_car          = car_reg;
                        emit_to           = CNT_W'(pick) + CNT_W'(1);
                    end else begin
                        failed_next = 1'b1;
                        emit_stat   = STAT_FAIL_NOW;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                // release the held move as the last one of this car
                if (slot_free) begin
                    fin_en     = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pending move and output word.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_car_next   = pend_car_reg;
        pend_from_next  = pend_from_reg;
        pend_to_next    = pend_to_reg;
        pend_stat_next  = pend_stat_reg;
        m_valid_next    = m_valid_reg;
        m_car_next      = m_car_reg;
        m_from_next     = m_from_reg;
        m_to_next       = m_to_reg;
        m_stat_next     = m_stat_reg;
        m_last_next     = m_last_reg;

        if (fin_en || (emit_en && pend_valid_reg)) begin
            m_valid_next = 1'b1;
            m_car_next   = pend_car_reg;
            m_from_next  = pend_from_reg;
            m_to_next    = pend_to_reg;
            m_stat_next  = pend_stat_reg;
            m_last_next  = fin_en;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (emit_en) begin
            pend_valid_next = 1'b1;
            pend_car_next   = emit_car;
            pend_from_next  = emit_from;
            pend_to_next    = emit_to;
            pend_stat_next  = emit_stat;
        end else if (fin_en) begin
            pend_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            next_exp_reg   <= CAR_W'(1);
            failed_reg     <= 1'b0;
            tc_reg         <= CNT_W'(MAX_TRACKS);
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int t = 0; t < MAX_TRACKS; t++) begin
                height_reg[t] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            next_exp_reg   <= next_exp_next;
            failed_reg     <= failed_next;
            tc_reg         <= tc_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            height_reg     <= height_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        car_reg       <= car_next;
        j_reg         <= j_next;
        n_reg         <= n_next;
        moved_reg     <= moved_next;
        hb_reg        <= hb_next;
        best_reg      <= best_next;
        best_top_reg  <= best_top_next;
        best_h_reg    <= best_h_next;
        he_reg        <= he_next;
        empty_reg     <= empty_next;
        top_reg       <= top_next;
        pend_car_reg  <= pend_car_next;
        pend_from_reg <= pend_from_next;
        pend_to_reg   <= pend_to_next;
        pend_stat_reg <= pend_stat_next;
        m_car_reg     <= m_car_next;
        m_from_reg    <= m_from_next;
        m_to_reg      <= m_to_next;
        m_stat_reg    <= m_stat_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_to_reg, m_from_reg, m_car_reg};
    assign m_tuser  = m_stat_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/rcr_track_mem.sv =====
// Car store for all holding tracks: one write port, one registered read port.
// Depends on rcr_pkg.
`timescale 1ns / 1ps

module rcr_track_mem (
    input  logic                       aclk,
    input  rcr_pkg::rcr_mem_req_t      req,
    output logic [rcr_pkg::CAR_W-1:0]  rd_data
);
    import rcr_pkg::*;

    logic [CAR_W-1:0] mem [1 << ADDR_W];
    logic [CAR_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/rcr_cmp_unit.sv =====
// Shared compare unit: tests one track top against the operand and the best top.
// Depends on rcr_pkg.
`timescale 1ns / 1ps

module rcr_cmp_unit (
    input  logic [rcr_pkg::CAR_W-1:0] operand,
    input  logic [rcr_pkg::CAR_W-1:0] top,
    input  logic [rcr_pkg::CAR_W-1:0] best_top,
    output rcr_pkg::rcr_cmp_t         res
);
    import rcr_pkg::*;

    always_comb begin
        res.eq         = (top == operand);
        res.fits       = (operand < top) && (top <= CAR_W'(MAX_CARS));
        res.below_best = (top < best_top);
    end

endmodule

// ===== bench/railroad_car_rearranger_unit_tb.sv =====
// Self-checking bench for the railroad car rearranger: directed table, then random and corner-case trains.
// Depends on rcr_pkg and railroad_car_rearranger_unit; predicts every move on its own.
`timescale 1ns / 1ps

module railroad_car_rearranger_unit_tb;
    import rcr_pkg::*;

    // Bounds of the run: stop cold at the cycle limit, settle before a register write,
    // and hold the receiver off for one long stretch.
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_CARS   = 220;

    // One move as it leaves the block.
    typedef struct packed {
        logic [CAR_W-1:0]  car;
        logic [3:0]        from_trk;
        logic [3:0]        to_trk;
        logic [STAT_W-1:0] status;
        logic              last;
    } move_t;

    // Directed rows: a car checked by the predictor, a car with its single move typed in,
    // or a write of the track count.
    typedef enum logic [1:0] {
        ROW_CAR,
        ROW_PINNED,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CAR_W-1:0]  car;
        logic              new_train;
        logic [CNT_W-1:0]  cfg;
        logic [CAR_W-1:0]  pin_car;
        logic [3:0]        pin_from;
        logic [3:0]        pin_to;
        logic [STAT_W-1:0] pin_stat;
    } row_t;

    localparam int DIRECTED_ROWS = 23;
    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        // straight out after reset, then park on the first two empty tracks
        '{ROW_PINNED, 6'd1,  1'b0, 4'd0,  6'd1,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_PINNED, 6'd3,  1'b0, 4'd0,  6'd3,  4'd0, 4'd1, STAT_MOVED},
        '{ROW_PINNED, 6'd5,  1'b0, 4'd0,  6'd5,  4'd0, 4'd2, STAT_MOVED},
        // smallest larger top wins, then car 2 drains three cars from two tracks
        '{ROW_CAR,    6'd4,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CAR,    6'd2,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        // no holding tracks: fail at once, then stay failed
        '{ROW_CFG,    6'd0,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_PINNED, 6'd7,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_FAIL_NOW},
        '{ROW_PINNED, 6'd6,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_FAIL_HELD},
        // count above the track maximum; new train clears the failure
        '{ROW_CFG,    6'd0,  1'b0, 4'd15, 6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_PINNED, 6'd63, 1'b1, 4'd0,  6'd63, 4'd0, 4'd1, STAT_MOVED},
        // a top above the car range is never suitable; car zero parks too
        '{ROW_CAR,    6'd0,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CAR,    6'd32, 1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CAR,    6'd31, 1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        // shrink the count mid-train: track three is ignored but keeps its cars
        '{ROW_CFG,    6'd0,  1'b0, 4'd2,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CAR,    6'd1,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CFG,    6'd0,  1'b0, 4'd8,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CAR,    6'd30, 1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        // one track, occupied by an unsuitable top
        '{ROW_CFG,    6'd0,  1'b0, 4'd1,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_PINNED, 6'd29, 1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_FAIL_NOW},
        '{ROW_CFG,    6'd0,  1'b0, 4'd8,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_PINNED, 6'd1,  1'b1, 4'd0,  6'd1,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CAR,    6'd42, 1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED},
        '{ROW_CAR,    6'd2,  1'b0, 4'd0,  6'd0,  4'd0, 4'd0, STAT_MOVED}
    };

    // Block ports; every input is known from time zero.
    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata     = '0;   // [5:0] car
    logic              s_tuser     = 1'b0; // [0] new_train
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [15:0]       m_tdata;            // [5:0] moved_car, [9:6] from, [13:10] to
    logic [1:0]        m_tuser;            // [1:0] status
    logic              m_tlast;

    // Predicted yard: tracks, heights, next car due, failure mark, track count.
    logic [CAR_W-1:0]  yard_store [MAX_TRACKS][STACK_DEPTH];
    int                yard_height [MAX_TRACKS] = '{default: 0};
    logic [CAR_W-1:0]  next_car     = 6'd1;
    logic              train_failed = 1'b0;
    logic [CNT_W-1:0]  track_limit  = 4'd8;

    move_t             step_moves [$];     // moves of the car just accepted
    move_t             awaited_moves [$];  // moves still to leave the block
    move_t             head_move;

    int unsigned       fault_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       cars_sent   = 0;
    bit                calm_phase  = 1'b0; // no random gaps on either side while set
    int unsigned       hold_asked  = 0;
    int unsigned       hold_served = 0;
    int unsigned       hold_left   = 0;
    int unsigned       rx_wait     = 0;

    railroad_car_rearranger_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop: a hung handshake must not run forever.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void log_move(input logic [CAR_W-1:0] car, input logic [3:0] from_trk,
                                     input logic [3:0] to_trk, input logic [STAT_W-1:0] stat);
        step_moves.push_back('{car, from_trk, to_trk, stat, 1'b0});
    endfunction

    // Work out every move one accepted car causes, and advance the predicted yard.
    task automatic forecast_moves(input logic [CAR_W-1:0] car, input logic new_train);
        int     k;
        int     h;
        int     best;
        int     best_top;
        int     empty;
        int     pick;
        bit     moved;
        bit     have_best;
        bit     have_empty;
        logic [CAR_W-1:0] top;
        move_t  tail;
        step_moves.delete();
        if (new_train) begin
            foreach (yard_height[j]) yard_height[j] = 0;
            train_failed = 1'b0;
            next_car     = 6'd1;
        end
        k = (track_limit > MAX_TRACKS) ? MAX_TRACKS : int'(track_limit);

        if (train_failed) begin
            log_move('0, 4'd0, 4'd0, STAT_FAIL_HELD);
        end else if (car == next_car) begin
            log_move(car, 4'd0, 4'd0, STAT_MOVED);
            next_car = next_car + 1'b1;
            // Sweep the tracks until a full pass moves nothing, or the move cap is hit.
            moved = 1'b1;
            while (moved && step_moves.size() < MAX_RESULTS) begin
                moved = 1'b0;
                for (int j = 0; j < k && step_moves.size() < MAX_RESULTS; j++) begin
                    h = yard_height[j];
                    if (h > 0 && h <= STACK_DEPTH && yard_store[j][h-1] == next_car) begin
                        log_move(yard_store[j][h-1], 4'(j + 1), 4'd0, STAT_MOVED);
                        yard_height[j] = h - 1;
                        next_car = next_car + 1'b1;
                        moved = 1'b1;
                    end
                end
            end
        end else begin
            have_best  = 1'b0;
            have_empty = 1'b0;
            best       = 0;
            best_top   = 0;
            empty      = 0;
            for (int j = 0; j < k; j++) begin
                h = yard_height[j];
                if (h > 0) begin
                    // a full track is skipped outright
                    if (h < STACK_DEPTH) begin
                        top = yard_store[j][h-1];
                        if (car < top && int'(top) <= MAX_CARS &&
                            (!have_best || int'(top) < best_top)) begin
                            have_best = 1'b1;
                            best      = j;
                            best_top  = int'(top);
                        end
                    end
                end else if (!have_empty) begin
                    have_empty = 1'b1;
                    empty      = j;
                end
            end
            if (have_best || have_empty) begin
                pick = have_best ? best : empty;
                yard_store[pick][yard_height[pick]] = car;
                yard_height[pick] = yard_height[pick] + 1;
                log_move(car, 4'd0, 4'(pick + 1), STAT_MOVED);
            end else begin
                train_failed = 1'b1;
                log_move('0, 4'd0, 4'd0, STAT_FAIL_NOW);
            end
        end

        tail = step_moves.pop_back();
        tail.last = 1'b1;
        step_moves.push_back(tail);
    endtask

    // Offer one car after a random gap; predict its moves at the accepting edge.
    task automatic offer_car(input logic [CAR_W-1:0] car, input logic new_train,
                             input bit pinned, input move_t pin);
        int unsigned gap;
        gap = calm_phase ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, car};
        s_tuser  <= new_train;
        do @(posedge aclk); while (!s_tready);
        forecast_moves(car, new_train);
        if (pinned) awaited_moves.push_back(pin);
        else foreach (step_moves[i]) awaited_moves.push_back(step_moves[i]);
        cars_sent++;
    endtask

    // Drop the input, wait out every awaited move, then let the block settle.
    task automatic settle_yard();
        s_tvalid <= 1'b0;
        while (awaited_moves.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_track_count(input logic [CNT_W-1:0] value);
        settle_yard();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        track_limit = value;
    endtask

    // A train of cars 1..len in random order, optionally with one car spoilt.
    task automatic run_train(input int len, input bit broken);
        logic [CAR_W-1:0] order [$];
        logic [CAR_W-1:0] swap;
        int               b;
        for (int c = 1; c <= len; c++) order.push_back(CAR_W'(c));
        for (int a = len - 1; a > 0; a--) begin
            b        = $urandom_range(0, a);
            swap     = order[a];
            order[a] = order[b];
            order[b] = swap;
        end
        if (broken) order[$urandom_range(0, len - 1)] = CAR_W'($urandom_range(0, 63));
        foreach (order[i]) offer_car(order[i], i == 0, 1'b0, '0);
    endtask

    // Mostly well-formed trains, with some noise, spoilt trains and count changes.
    task automatic mixed_traffic(input int unsigned goal);
        int unsigned pick;
        int          len;
        while (cars_sent < goal) begin
            calm_phase = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 15);
            if (pick < 3) begin
                set_track_count(($urandom_range(0, 5) == 0) ? CNT_W'($urandom_range(0, 15))
                                                            : CNT_W'($urandom_range(1, 8)));
            end else if (pick < 5) begin
                repeat ($urandom_range(1, 4))
                    offer_car(CAR_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                              1'b0, '0);
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 32)
                                                  : $urandom_range(2, 10);
                run_train(len, pick == 5);
            end
        end
    endtask

    // Receiver: draw a wait after every word, and serve a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_tready  <= 1'b0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                rx_wait = calm_phase ? 0 : $urandom_range(0, 7);
                if (rx_wait != 0) m_tready <= 1'b0;
            end
        end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // Compare each accepted word with the oldest awaited move.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_moves.size() == 0) begin
                $error("move word with none awaited: car %0d from %0d to %0d status %0d",
                       m_tdata[5:0], m_tdata[9:6], m_tdata[13:10], m_tuser);
                fault_count++;
            end else begin
                head_move = awaited_moves.pop_front();
                check_field("moved_car",  32'(head_move.car),      32'(m_tdata[5:0]));
                check_field("from_track", 32'(head_move.from_trk), 32'(m_tdata[9:6]));
                check_field("to_track",   32'(head_move.to_trk),   32'(m_tdata[13:10]));
                check_field("status",     32'(head_move.status),   32'(m_tuser));
                check_field("last",       32'(head_move.last),     32'(m_tlast));
            end
        end
    end

    initial begin : stimulus
        row_t        row;
        move_t       pin_move;
        int unsigned random_goal;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: typed moves where obvious, the predictor elsewhere.
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG) begin
                set_track_count(row.cfg);
            end else begin
                pin_move = '{row.pin_car, row.pin_from, row.pin_to, row.pin_stat, 1'b1};
                offer_car(row.car, row.new_train, row.kind == ROW_PINNED, pin_move);
            end
        end

        random_goal = cars_sent + RANDOM_CARS;
        mixed_traffic(cars_sent + 60);

        // Hold the receiver off while the sender streams a train at full rate.
        set_track_count(4'd8);
        calm_phase = 1'b1;
        hold_asked++;
        run_train(16, 1'b0);

        // Move cap: one track of 32 down to 2, car 33 aside, then car 1 drains 31.
        set_track_count(4'd2);
        calm_phase = ($urandom_range(0, 1) == 0);
        for (int c = 32; c >= 2; c--) offer_car(CAR_W'(c), c == 32, 1'b0, '0);
        offer_car(6'd33, 1'b0, 1'b0, '0);
        offer_car(6'd1,  1'b0, 1'b0, '0);
        offer_car(6'd34, 1'b0, 1'b0, '0);
        offer_car(6'd33, 1'b0, 1'b0, '0);

        // Full track: fill the only track to its depth, then offer twice more.
        set_track_count(4'd1);
        for (int c = 32; c >= 2; c--) offer_car(CAR_W'(c), c == 32, 1'b0, '0);
        offer_car(6'd0, 1'b0, 1'b0, '0);
        offer_car(6'd0, 1'b0, 1'b0, '0);
        offer_car(6'd5, 1'b0, 1'b0, '0);

        // Counter wrap: run 1..63 straight through, then 0 and 1 again.
        set_track_count(CNT_W'($urandom_range(1, 8)));
        calm_phase = ($urandom_range(0, 1) == 0);
        for (int c = 1; c <= 63; c++) offer_car(CAR_W'(c), c == 1, 1'b0, '0);
        offer_car(6'd0, 1'b0, 1'b0, '0);
        offer_car(6'd1, 1'b0, 1'b0, '0);

        mixed_traffic(random_goal);

        settle_yard();
        repeat (64) @(posedge aclk);
        if (awaited_moves.size() != 0)
            $error("%0d moves never arrived", awaited_moves.size());
        if (fault_count == 0 && awaited_moves.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
